[sv/two_level_lru_cache_model_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the two-level cache tag model
// Clocked concurrent assertion wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_LRU_CACHE_MODEL_MACROS_SVH
`define TWO_LEVEL_LRU_CACHE_MODEL_MACROS_SVH

// Checked only outside reset
`define TLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define TLC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/tlc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types, codes and geometry helper for the two-level cache tag model.
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_L1_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_ASSOC = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_ASSOC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WR_ALLOC = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_LAT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_LAT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_LAT  = 3'd7;

  localparam logic [1:0] OP_PROBE = 2'd0;
  localparam logic [1:0] OP_FILL  = 2'd1;
  localparam logic [1:0] OP_DROP  = 2'd2;

  localparam logic LVL_L1 = 1'b0;
  localparam logic LVL_L2 = 1'b1;

  localparam logic ASEL_ACC = 1'b0;
  localparam logic ASEL_EV  = 1'b1;

  typedef struct packed {
    logic       clr;
    logic       latch_in;
    logic       begin_pass;
    logic       lvl;
    logic       asel;
    logic       rd;
    logic       wr;
    logic       op;
    logic [1:0] op_code;
    logic       op_dirty;
    logic       cnt_l1;
    logic       cnt_l1miss;
    logic       cnt_l2miss;
    logic       rec_h1;
    logic       rec_h2;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic way_last;
    logic hit;
    logic evicted;
    logic ev_dirty;
    logic alloc;
    logic is_write;
  } status_t;

  typedef struct packed {
    logic [4:0] set_bits;
    logic [1:0] wl2;
  } geom_t;

  function automatic geom_t calc_geom(logic [3:0] size_bits, logic [1:0] assoc_bits,
                                      int max_log2, int block_bits, int ways_log2);
    int    lines;
    int    ways;
    geom_t g;
    lines = (int'(size_bits) > block_bits) ? int'(size_bits) - block_bits : 0;
    if (lines > max_log2) lines = max_log2;
    ways = int'(assoc_bits);
    if (ways > lines) ways = lines;
    if (ways > ways_log2) ways = ways_log2;
    g.set_bits = 5'(lines - ways);
    g.wl2      = 2'(ways);
    return g;
  endfunction

endpackage

[sv/two_level_lru_cache_model.sv]
`timescale 1ns / 1ps
// Each set pass reads its ways one per cycle and writes them back one per cycle through
// the separate read and write ports of the tag memory; a request runs 1 to 6 set passes.
// Requests are taken one at a time.
// Reset: synchronous; afterwards a clearing sweep over every address of both tag
// memories zeroes them before the first request.
// ----------------------------------------------------------------------------
// two_level_lru_cache_model
// Two-level inclusive write-back LRU cache tag model with hit/miss counters.
// ----------------------------------------------------------------------------
module two_level_lru_cache_model #(
  parameter int BLOCK_BITS    = 4,
  parameter int L1_LINES_LOG2 = 6,
  parameter int L2_LINES_LOG2 = 8,
  parameter int WAYS_LOG2     = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_func,
  input  logic [31:0]                    in_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_l1_hit,
  output logic                           out_l2_hit,
  output logic [31:0]                    out_l1_access_count,
  output logic [31:0]                    out_l1_miss_count,
  output logic [31:0]                    out_l2_access_count,
  output logic [31:0]                    out_l2_miss_count,
  output logic [47:0]                    out_cycle_total,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tlc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlc_pkg::CFG_DATA_W-1:0] cfg_data
);

  tlc_pkg::cmd_t    cmd;
  tlc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  tlc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .cmd(cmd)
  );

  tlc_dp #(
    .BLOCK_BITS(BLOCK_BITS), .L1_LINES_LOG2(L1_LINES_LOG2),
    .L2_LINES_LOG2(L2_LINES_LOG2), .WAYS_LOG2(WAYS_LOG2)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
    .cfg_we(cfg_valid & cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_func(in_func), .in_address(in_address),
    .out_l1_hit(out_l1_hit), .out_l2_hit(out_l2_hit),
    .out_l1_access_count(out_l1_access_count),
    .out_l1_miss_count(out_l1_miss_count),
    .out_l2_access_count(out_l2_access_count),
    .out_l2_miss_count(out_l2_miss_count),
    .out_cycle_total(out_cycle_total)
  );

endmodule

[sv/tlc_tagmem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlc_tagmem
// Single write, single read tag line memory with registered read data.
// ----------------------------------------------------------------------------
module tlc_tagmem #(
  parameter int AW = 6,
  parameter int DW = 37
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [1<<AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/tlc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlc_dp
// Datapath: config registers, tag memories, set buffer, LRU update, counters.
// ----------------------------------------------------------------------------
module tlc_dp #(
  parameter int BLOCK_BITS    = 4,
  parameter int L1_LINES_LOG2 = 6,
  parameter int L2_LINES_LOG2 = 8,
  parameter int WAYS_LOG2     = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tlc_pkg::cmd_t                  cmd,
  output tlc_pkg::status_t               status,
  input  logic                           cfg_we,
  input  logic [tlc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_func,
  input  logic [31:0]                    in_address,
  output logic                           out_l1_hit,
  output logic                           out_l2_hit,
  output logic [31:0]                    out_l1_access_count,
  output logic [31:0]                    out_l1_miss_count,
  output logic [31:0]                    out_l2_access_count,
  output logic [31:0]                    out_l2_miss_count,
  output logic [47:0]                    out_cycle_total
);

  localparam int RW = (WAYS_LOG2 > 0) ? WAYS_LOG2 : 1;
  localparam int WW = RW;
  localparam int NW = 1 << WAYS_LOG2;
  localparam int EW = 34 + RW;
  localparam int CW = (L1_LINES_LOG2 > L2_LINES_LOG2) ? L1_LINES_LOG2 : L2_LINES_LOG2;

  typedef struct packed {
    logic          valid;
    logic          dirty;
    logic [31:0]   tag;
    logic [RW-1:0] rank;
  } entry_t;

  // configuration
  logic [3:0] l1_size_r, l2_size_r;
  logic [1:0] l1_assoc_r, l2_assoc_r;
  logic       wa_r;
  logic [7:0] l1_lat_r, l2_lat_r;
  logic [9:0] mem_lat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_size_r  <= 4'd10;
      l1_assoc_r <= 2'd0;
      l2_size_r  <= 4'd12;
      l2_assoc_r <= 2'd0;
      wa_r       <= 1'b1;
      l1_lat_r   <= 8'd1;
      l2_lat_r   <= 8'd10;
      mem_lat_r  <= 10'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        tlc_pkg::CFG_L1_SIZE:  l1_size_r  <= cfg_data[3:0];
        tlc_pkg::CFG_L1_ASSOC: l1_assoc_r <= cfg_data[1:0];
        tlc_pkg::CFG_L2_SIZE:  l2_size_r  <= cfg_data[3:0];
        tlc_pkg::CFG_L2_ASSOC: l2_assoc_r <= cfg_data[1:0];
        tlc_pkg::CFG_WR_ALLOC: wa_r       <= cfg_data[0];
        tlc_pkg::CFG_L1_LAT:   l1_lat_r   <= cfg_data[7:0];
        tlc_pkg::CFG_L2_LAT:   l2_lat_r   <= cfg_data[7:0];
        tlc_pkg::CFG_MEM_LAT:  mem_lat_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // pass state
  logic          lvl_r;
  logic [31:0]   pa_r, addr_r, ev_addr_r;
  logic          func_r;
  logic [WW-1:0] way_r, rd_way_r;
  logic          rd_pend_r;
  logic          hit_r, evicted_r, ev_dirty_r, h1_r, h2_r;
  logic [CW-1:0] clr_cnt_r;
  entry_t        buf_r [NW];

  tlc_pkg::geom_t g1, g2, gs;
  logic [31:0]   set_v, tag_v, idx_v, ways_m1_w, ev_addr_v;
  logic [5:0]    sh;
  logic [WW-1:0] ways_m1;
  logic          way_last;

  assign g1 = tlc_pkg::calc_geom(l1_size_r, l1_assoc_r, L1_LINES_LOG2, BLOCK_BITS, WAYS_LOG2);
  assign g2 = tlc_pkg::calc_geom(l2_size_r, l2_assoc_r, L2_LINES_LOG2, BLOCK_BITS, WAYS_LOG2);
  assign gs = (lvl_r == tlc_pkg::LVL_L2) ? g2 : g1;

  assign set_v     = (pa_r >> BLOCK_BITS) & ((32'd1 << gs.set_bits) - 32'd1);
  assign sh        = 6'(BLOCK_BITS) + {1'b0, gs.set_bits};
  assign tag_v     = pa_r >> sh;
  assign ways_m1_w = (32'd1 << gs.wl2) - 32'd1;
  assign ways_m1   = ways_m1_w[WW-1:0];
  assign way_last  = (way_r == ways_m1);
  assign idx_v     = (set_v << gs.wl2) | 32'(way_r);

  // tag memories
  logic                     we1, we2;
  logic [L1_LINES_LOG2-1:0] wa1;
  logic [L2_LINES_LOG2-1:0] wa2;
  logic [EW-1:0]            wdata, rdata1, rdata2;

  assign we1   = cmd.clr | (cmd.wr & (lvl_r == tlc_pkg::LVL_L1));
  assign we2   = cmd.clr | (cmd.wr & (lvl_r == tlc_pkg::LVL_L2));
  assign wa1   = cmd.clr ? clr_cnt_r[L1_LINES_LOG2-1:0] : idx_v[L1_LINES_LOG2-1:0];
  assign wa2   = cmd.clr ? clr_cnt_r[L2_LINES_LOG2-1:0] : idx_v[L2_LINES_LOG2-1:0];
  assign wdata = cmd.clr ? '0 : EW'(buf_r[way_r]);

  tlc_tagmem #(.AW(L1_LINES_LOG2), .DW(EW)) u_l1mem (
    .clk(clk), .we(we1), .waddr(wa1), .wdata(wdata),
    .raddr(idx_v[L1_LINES_LOG2-1:0]), .rdata(rdata1)
  );

  tlc_tagmem #(.AW(L2_LINES_LOG2), .DW(EW)) u_l2mem (
    .clk(clk), .we(we2), .waddr(wa2), .wdata(wdata),
    .raddr(idx_v[L2_LINES_LOG2-1:0]), .rdata(rdata2)
  );

  // set operation: probe, fill or drop, with LRU rank update across ways on a probe hit or a fill
  logic [NW-1:0] act, match, inv, r0;
  logic [WW-1:0] hit_w, inv_w, r0_w, tw;
  logic          any_hit, any_inv, do_promote;
  logic [RW-1:0] old_rank;
  entry_t        nb [NW];

  always_comb begin
    hit_w = '0;
    inv_w = '0;
    r0_w  = '0;
    for (int w = 0; w < NW; w++) begin
      act[w]   = (w <= int'(ways_m1));
      match[w] = act[w] & buf_r[w].valid & (buf_r[w].tag == tag_v);
      inv[w]   = act[w] & ~buf_r[w].valid;
      r0[w]    = act[w] & (buf_r[w].rank == '0);
    end
    for (int w = NW - 1; w >= 0; w--) begin
      if (match[w]) hit_w = WW'(w);
      if (inv[w])   inv_w = WW'(w);
      if (r0[w])    r0_w  = WW'(w);
    end
    any_hit = |match;
    any_inv = |inv;
    // full set with no rank zero falls back to way 0
    tw = (cmd.op_code == tlc_pkg::OP_FILL) ? (any_inv ? inv_w : r0_w) : hit_w;
    do_promote = ((cmd.op_code == tlc_pkg::OP_PROBE) & any_hit) |
                 (cmd.op_code == tlc_pkg::OP_FILL);
    old_rank = buf_r[tw].rank;
    for (int w = 0; w < NW; w++) begin
      nb[w] = buf_r[w];
      if (do_promote && act[w]) begin
        if (WW'(w) == tw) begin
          nb[w].rank = ways_m1_w[RW-1:0];
        end else if (buf_r[w].rank > old_rank) begin
          nb[w].rank = buf_r[w].rank - RW'(1);
        end
      end
    end
    case (cmd.op_code)
      tlc_pkg::OP_PROBE: begin
        if (any_hit && cmd.op_dirty) nb[tw].dirty = 1'b1;
      end
      tlc_pkg::OP_FILL: begin
        nb[tw].valid = 1'b1;
        nb[tw].tag   = tag_v;
        nb[tw].dirty = cmd.op_dirty;
      end
      tlc_pkg::OP_DROP: begin
        if (any_hit) nb[tw] = '0;
      end
      default: ;
    endcase
    ev_addr_v = (buf_r[tw].tag << sh) | (set_v << BLOCK_BITS);
  end

  always_ff @(posedge clk) begin
    if (cmd.begin_pass) begin
      lvl_r <= cmd.lvl;
      pa_r  <= (cmd.asel == tlc_pkg::ASEL_EV) ? ev_addr_r : addr_r;
    end
    if (cmd.latch_in) begin
      func_r <= in_func;
      addr_r <= in_address;
    end
    rd_way_r <= way_r;
    if (rd_pend_r) begin
      buf_r[rd_way_r] <= (lvl_r == tlc_pkg::LVL_L2) ? entry_t'(rdata2) : entry_t'(rdata1);
    end else if (cmd.op) begin
      buf_r <= nb;
    end
    if (cmd.op) begin
      hit_r      <= any_hit;
      evicted_r  <= (cmd.op_code == tlc_pkg::OP_FILL) & ~any_inv;
      ev_dirty_r <= buf_r[tw].dirty;
      if (cmd.op_code == tlc_pkg::OP_FILL) ev_addr_r <= ev_addr_v;
    end
  end

  // counters and result register
  logic [31:0] acc1_r, miss1_r, acc2_r, miss2_r;
  logic [47:0] cyc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      way_r     <= '0;
      rd_pend_r <= 1'b0;
      clr_cnt_r <= '0;
      acc1_r    <= '0;
      miss1_r   <= '0;
      acc2_r    <= '0;
      miss2_r   <= '0;
      cyc_r     <= '0;
      h1_r      <= 1'b0;
      h2_r      <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd;
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + CW'(1);
      if (cmd.begin_pass) begin
        way_r <= '0;
      end else if (cmd.rd || cmd.wr) begin
        way_r <= way_last ? '0 : way_r + WW'(1);
      end
      if (cmd.latch_in) begin
        h1_r <= 1'b0;
        h2_r <= 1'b0;
      end
      if (cmd.rec_h1) h1_r <= hit_r;
      if (cmd.rec_h2) h2_r <= hit_r;
      if (cmd.cnt_l1) begin
        acc1_r <= acc1_r + 32'd1;
        cyc_r  <= cyc_r + 48'(l1_lat_r);
      end
      if (cmd.cnt_l1miss) begin
        miss1_r <= miss1_r + 32'd1;
        acc2_r  <= acc2_r + 32'd1;
        cyc_r   <= cyc_r + 48'(l2_lat_r);
      end
      if (cmd.cnt_l2miss) begin
        miss2_r <= miss2_r + 32'd1;
        cyc_r   <= cyc_r + 48'(mem_lat_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_l1_hit          <= h1_r;
      out_l2_hit          <= h2_r;
      out_l1_access_count <= acc1_r;
      out_l1_miss_count   <= miss1_r;
      out_l2_access_count <= acc2_r;
      out_l2_miss_count   <= miss2_r;
      out_cycle_total     <= cyc_r;
    end
  end

  assign status.clr_last = &clr_cnt_r;
  assign status.way_last = way_last;
  assign status.hit      = hit_r;
  assign status.evicted  = evicted_r;
  assign status.ev_dirty = ev_dirty_r;
  assign status.alloc    = ~func_r | wa_r;
  assign status.is_write = func_r;

endmodule

[sv/tlc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlc_ctrl
// Sequencer: clearing sweep, then per request a chain of set passes.
// ----------------------------------------------------------------------------
module tlc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  tlc_pkg::status_t status,
  output tlc_pkg::cmd_t    cmd
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_BEGIN = 4'd2;
  localparam logic [3:0] ST_RD    = 4'd3;
  localparam logic [3:0] ST_WAIT  = 4'd4;
  localparam logic [3:0] ST_OP    = 4'd5;
  localparam logic [3:0] ST_WR    = 4'd6;
  localparam logic [3:0] ST_NEXT  = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  // pass kinds
  localparam logic [2:0] SP_L1PROBE = 3'd0;
  localparam logic [2:0] SP_L2PROBE = 3'd1;
  localparam logic [2:0] SP_FILL1   = 3'd2;
  localparam logic [2:0] SP_WBACK   = 3'd3;
  localparam logic [2:0] SP_FILL2   = 3'd4;
  localparam logic [2:0] SP_DROP    = 3'd5;

  logic [3:0] state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic       p_lvl, p_asel, p_dirty;
  logic [1:0] p_op;

  always_comb begin
    p_lvl   = tlc_pkg::LVL_L1;
    p_asel  = tlc_pkg::ASEL_ACC;
    p_op    = tlc_pkg::OP_PROBE;
    p_dirty = status.is_write;
    case (step_r)
      SP_L1PROBE: ;
      SP_L2PROBE: p_lvl = tlc_pkg::LVL_L2;
      SP_FILL1: begin
        p_op    = tlc_pkg::OP_FILL;
        p_dirty = 1'b0;
      end
      SP_WBACK: begin
        p_lvl   = tlc_pkg::LVL_L2;
        p_asel  = tlc_pkg::ASEL_EV;
        p_dirty = 1'b1;
      end
      SP_FILL2: begin
        p_lvl = tlc_pkg::LVL_L2;
        p_op  = tlc_pkg::OP_FILL;
      end
      SP_DROP: begin
        p_asel = tlc_pkg::ASEL_EV;
        p_op   = tlc_pkg::OP_DROP;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '0;
    cmd.lvl       = p_lvl;
    cmd.asel      = p_asel;
    cmd.op_code   = p_op;
    cmd.op_dirty  = p_dirty;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          cmd.cnt_l1   = 1'b1;
          step_nxt     = SP_L1PROBE;
          state_nxt    = ST_BEGIN;
        end
      end
      ST_BEGIN: begin
        cmd.begin_pass = 1'b1;
        state_nxt      = ST_RD;
      end
      ST_RD: begin
        cmd.rd = 1'b1;
        if (status.way_last) state_nxt = ST_WAIT;
      end
      ST_WAIT: state_nxt = ST_OP;
      ST_OP: begin
        cmd.op    = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        cmd.wr = 1'b1;
        if (status.way_last) state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        state_nxt = ST_BEGIN;
        case (step_r)
          SP_L1PROBE: begin
            cmd.rec_h1 = 1'b1;
            if (status.hit) begin
              state_nxt = ST_DONE;
            end else begin
              cmd.cnt_l1miss = 1'b1;
              step_nxt       = SP_L2PROBE;
            end
          end
          SP_L2PROBE: begin
            cmd.rec_h2 = 1'b1;
            if (!status.hit) cmd.cnt_l2miss = 1'b1;
            if (!status.alloc) state_nxt = ST_DONE;
            else if (status.hit) step_nxt = SP_FILL1;
            else step_nxt = SP_FILL2;
          end
          SP_FILL1: begin
            // dirty L1 victim is pushed into L2 uncounted
            if (status.evicted && status.ev_dirty) step_nxt = SP_WBACK;
            else state_nxt = ST_DONE;
          end
          SP_FILL2: begin
            // inclusion: L2 victim leaves L1 too
            if (status.evicted) step_nxt = SP_DROP;
            else step_nxt = SP_FILL1;
          end
          SP_DROP:  step_nxt = SP_FILL1;
          default:  state_nxt = ST_DONE;
        endcase
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      step_r      <= SP_L1PROBE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[sv/tlc_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlc_chk
// Port-level checks on request/result sequencing of the cache tag model.
// ----------------------------------------------------------------------------
`include "two_level_lru_cache_model_macros.svh"

module tlc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [47:0] out_cycle_total
);

  `TLC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `TLC_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_cycle_total), "result changed while stalled")
  `TLC_ASSERT(a_one_at_a_time, in_valid && !in_stall |=> in_stall, "request taken while busy")
  `TLC_ASSERT_RST(a_reset, !rst_n |=> in_stall && !out_valid, "reset did not quiesce block")

endmodule

bind two_level_lru_cache_model tlc_chk u_tlc_chk (.*);

[sim/tb_two_level_lru_cache_model.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_level_lru_cache_model
// Self-checking bench for the two-level cache tag model: requests are predicted
// by a behavioral tag model of both levels and results are compared in order,
// across several cache geometries, allocate modes and latency settings.
// ----------------------------------------------------------------------------

typedef struct {
  bit        ok;
  bit        dirty;
  bit [31:0] tag;
  int        rank;
} tag_line_t;

typedef struct {
  bit        l1_hit;
  bit        l2_hit;
  bit [31:0] l1_acc;
  bit [31:0] l1_miss;
  bit [31:0] l2_acc;
  bit [31:0] l2_miss;
  bit [47:0] cycles;
} access_result_t;

class cache_scoreboard;
  tag_line_t      l1_lines[64];
  tag_line_t      l2_lines[256];
  bit [31:0]      l1_acc, l1_miss, l2_acc, l2_miss;
  bit [47:0]      cycles;
  bit [3:0]       l1_size;
  bit [1:0]       l1_assoc;
  bit [3:0]       l2_size;
  bit [1:0]       l2_assoc;
  bit             wr_alloc;
  bit [7:0]       l1_lat, l2_lat;
  bit [9:0]       mem_lat;
  access_result_t pending[$];
  int             mismatches;

  function new();
    foreach (l1_lines[i]) l1_lines[i] = '{0, 0, 0, 0};
    foreach (l2_lines[i]) l2_lines[i] = '{0, 0, 0, 0};
    l1_size = 10; l1_assoc = 0; l2_size = 12; l2_assoc = 0; wr_alloc = 1;
    l1_lat = 1; l2_lat = 10; mem_lat = 100;
  endfunction

  function void set_reg(logic [tlc_pkg::CFG_IDX_W-1:0] idx,
                        logic [tlc_pkg::CFG_DATA_W-1:0] v);
    case (idx)
      tlc_pkg::CFG_L1_SIZE:  l1_size = v[3:0];
      tlc_pkg::CFG_L1_ASSOC: l1_assoc = v[1:0];
      tlc_pkg::CFG_L2_SIZE:  l2_size = v[3:0];
      tlc_pkg::CFG_L2_ASSOC: l2_assoc = v[1:0];
      tlc_pkg::CFG_WR_ALLOC: wr_alloc = v[0];
      tlc_pkg::CFG_L1_LAT:   l1_lat = v[7:0];
      tlc_pkg::CFG_L2_LAT:   l2_lat = v[7:0];
      tlc_pkg::CFG_MEM_LAT:  mem_lat = v[9:0];
      default: ;
    endcase
  endfunction

  // geometry: set index width and way count
  function void shape(bit second, output int sbits, output int nways);
    int lines, wl;
    lines = second ? int'(l2_size) : int'(l1_size);
    lines = lines > 4 ? lines - 4 : 0;
    if (lines > (second ? 8 : 6)) lines = second ? 8 : 6;
    wl = second ? int'(l2_assoc) : int'(l1_assoc);
    if (wl > lines) wl = lines;
    if (wl > 3) wl = 3;
    sbits = lines - wl;
    nways = 1 << wl;
  endfunction

  function tag_line_t rd(bit second, int i);
    return second ? l2_lines[i] : l1_lines[i];
  endfunction

  function void wr(bit second, int i, tag_line_t l);
    if (second) l2_lines[i] = l; else l1_lines[i] = l;
  endfunction

  function void bump(bit second, int base, int nways, int way);
    tag_line_t l;
    int prev;
    l = rd(second, base + way);
    prev = l.rank;
    l.rank = nways - 1;
    wr(second, base + way, l);
    for (int w = 0; w < nways; w++) begin
      l = rd(second, base + w);
      if (w != way && l.rank > prev) begin
        l.rank--;
        wr(second, base + w, l);
      end
    end
  endfunction

  function void locate(bit second, bit [31:0] a, output int base, output int nways,
                       output bit [31:0] tg, output int sbits);
    int s;
    shape(second, sbits, nways);
    s = (a >> 4) & ((1 << sbits) - 1);
    base = s * nways;
    tg = (4 + sbits >= 32) ? 0 : a >> (4 + sbits);
  endfunction

  function bit lookup(bit second, bit [31:0] a, bit mark);
    int base, nways, sbits;
    bit [31:0] tg;
    tag_line_t l;
    locate(second, a, base, nways, tg, sbits);
    for (int w = 0; w < nways; w++) begin
      l = rd(second, base + w);
      if (l.ok && l.tag == tg) begin
        if (mark) begin
          l.dirty = 1;
          wr(second, base + w, l);
        end
        bump(second, base, nways, w);
        return 1;
      end
    end
    return 0;
  endfunction

  function bit allocate(bit second, bit [31:0] a, bit d, output bit [31:0] ev_a,
                        output bit ev_d);
    int base, nways, sbits, victim;
    bit [31:0] tg;
    tag_line_t l;
    locate(second, a, base, nways, tg, sbits);
    ev_a = 0; ev_d = 0;
    for (int w = 0; w < nways; w++) begin
      l = rd(second, base + w);
      if (!l.ok) begin
        l.ok = 1; l.tag = tg; l.dirty = d;
        wr(second, base + w, l);
        bump(second, base, nways, w);
        return 0;
      end
    end
    victim = 0;
    for (int w = 0; w < nways; w++) begin
      l = rd(second, base + w);
      if (l.rank == 0) begin
        victim = w;
        break;
      end
    end
    l = rd(second, base + victim);
    ev_d = l.dirty;
    ev_a = ((4 + sbits >= 32) ? 32'd0 : (l.tag << (4 + sbits))) | ((base / nways) << 4);
    l.ok = 1; l.tag = tg; l.dirty = d;
    wr(second, base + victim, l);
    bump(second, base, nways, victim);
    return 1;
  endfunction

  function void invalidate_l1(bit [31:0] a);
    int base, nways, sbits;
    bit [31:0] tg;
    locate(0, a, base, nways, tg, sbits);
    for (int w = 0; w < nways; w++)
      if (l1_lines[base + w].ok && l1_lines[base + w].tag == tg) begin
        l1_lines[base + w] = '{0, 0, 0, 0};
        return;
      end
  endfunction

  function void fill_l1(bit [31:0] a);
    bit [31:0] ea;
    bit ed;
    if (allocate(0, a, 0, ea, ed) && ed) void'(lookup(1, ea, 1));
  endfunction

  function void fill_l2(bit [31:0] a, bit d);
    bit [31:0] ea;
    bit ed;
    if (allocate(1, a, d, ea, ed)) invalidate_l1(ea);
  endfunction

  function void note_request(bit is_wr, bit [31:0] a);
    access_result_t r;
    bit h1, h2;
    h2 = 0;
    l1_acc++;
    h1 = lookup(0, a, is_wr);
    cycles += l1_lat;
    if (!h1) begin
      l1_miss++;
      l2_acc++;
      h2 = lookup(1, a, is_wr);
      cycles += l2_lat;
      if (h2) begin
        if (!is_wr || wr_alloc) fill_l1(a);
      end else begin
        l2_miss++;
        cycles += mem_lat;
        if (!is_wr || wr_alloc) begin
          fill_l2(a, is_wr);
          fill_l1(a);
        end
      end
    end
    r = '{h1, h2, l1_acc, l1_miss, l2_acc, l2_miss, cycles};
    pending.push_back(r);
  endfunction

  function void check_result(access_result_t got);
    access_result_t exp;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      return;
    end
    exp = pending.pop_front();
    if (got.l1_hit != exp.l1_hit || got.l2_hit != exp.l2_hit ||
        got.l1_acc != exp.l1_acc || got.l1_miss != exp.l1_miss ||
        got.l2_acc != exp.l2_acc || got.l2_miss != exp.l2_miss ||
        got.cycles != exp.cycles) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch at %0t: exp h1=%0d h2=%0d %0d %0d %0d %0d cyc=%0d",
                  " | got h1=%0d h2=%0d %0d %0d %0d %0d cyc=%0d"},
                 $realtime, exp.l1_hit, exp.l2_hit, exp.l1_acc, exp.l1_miss, exp.l2_acc,
                 exp.l2_miss, exp.cycles, got.l1_hit, got.l2_hit, got.l1_acc,
                 got.l1_miss, got.l2_acc, got.l2_miss, got.cycles);
    end
  endfunction
endclass

module tb_two_level_lru_cache_model;
  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic                           in_func;
  logic [31:0]                    in_address;
  logic                           out_valid;
  logic                           out_stall;
  logic                           out_l1_hit;
  logic                           out_l2_hit;
  logic [31:0]                    out_l1_access_count;
  logic [31:0]                    out_l1_miss_count;
  logic [31:0]                    out_l2_access_count;
  logic [31:0]                    out_l2_miss_count;
  logic [47:0]                    out_cycle_total;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [tlc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tlc_pkg::CFG_DATA_W-1:0] cfg_data;

  cache_scoreboard sb;
  int              send_idle_pct;
  int              recv_idle_pct;
  longint          cycle_cnt = 0;
  bit [31:0]       recent[$];

  two_level_lru_cache_model DUT (.*);

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 3000000) begin
      $display("tb_two_level_lru_cache_model: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_l1_hit, out_l2_hit, out_l1_access_count, out_l1_miss_count,
                        out_l2_access_count, out_l2_miss_count, out_cycle_total});
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // valid stays up after an accept so back-to-back requests need no gap
  task automatic send_request(bit is_wr, bit [31:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= is_wr;
    in_address <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(is_wr, a);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [tlc_pkg::CFG_IDX_W-1:0] idx,
                           logic [tlc_pkg::CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic set_geometry(int s1, int a1, int s2, int a2, bit wa,
                              int lat1, int lat2, int latm);
    drain();
    write_reg(tlc_pkg::CFG_L1_SIZE, tlc_pkg::CFG_DATA_W'(s1));
    write_reg(tlc_pkg::CFG_L1_ASSOC, tlc_pkg::CFG_DATA_W'(a1));
    write_reg(tlc_pkg::CFG_L2_SIZE, tlc_pkg::CFG_DATA_W'(s2));
    write_reg(tlc_pkg::CFG_L2_ASSOC, tlc_pkg::CFG_DATA_W'(a2));
    write_reg(tlc_pkg::CFG_WR_ALLOC, tlc_pkg::CFG_DATA_W'(wa));
    write_reg(tlc_pkg::CFG_L1_LAT, tlc_pkg::CFG_DATA_W'(lat1));
    write_reg(tlc_pkg::CFG_L2_LAT, tlc_pkg::CFG_DATA_W'(lat2));
    write_reg(tlc_pkg::CFG_MEM_LAT, tlc_pkg::CFG_DATA_W'(latm));
    cfg_valid <= 1'b0;
  endtask

  // mostly reuse of recent lines and a small footprint, some wide addresses
  function automatic bit [31:0] pick_address();
    int k;
    k = $urandom_range(99);
    if (k < 45 && recent.size() > 0)
      return recent[$urandom_range(recent.size() - 1)] ^ $urandom_range(15);
    if (k < 85) return $urandom_range(32'h3fff);
    return $urandom;
  endfunction

  task automatic random_phase(int n);
    bit [31:0] a;
    for (int i = 0; i < n; i++) begin
      a = pick_address();
      recent.push_back(a);
      if (recent.size() > 24) void'(recent.pop_front());
      send_request(1'($urandom_range(1)), a);
    end
  endtask

  initial begin
    sb = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_func    = 1'b0;
    in_address = '0;
    out_stall  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset geometry, hits, misses, address extremes
    send_request(0, 32'h0);
    send_request(0, 32'h0);
    send_request(1, 32'h4);
    send_request(1, 32'hffff_ffff);
    send_request(0, 32'hffff_fff0);
    send_request(0, 32'h0000_0400);
    send_request(0, 32'h0000_0000);
    send_request(1, 32'h8000_0000);
    send_request(1, 32'h5555_5555);
    send_request(0, 32'haaaa_aaaa);
    // tiny caches: one line each, write-no-allocate and L1 invalidation
    set_geometry(4, 3, 4, 3, 0, 255, 255, 1023);
    send_request(1, 32'h10);
    send_request(0, 32'h10);
    send_request(1, 32'h20);
    send_request(0, 32'h30);
    send_request(1, 32'h30);
    send_request(0, 32'h10);
    // associative, write-allocate, L2 evictions that invalidate L1 lines
    set_geometry(6, 3, 8, 1, 1, 0, 0, 0);
    for (int i = 0; i < 8; i++) send_request(1, i * 32'h40);

    send_idle_pct = 24; recv_idle_pct = 86;
    set_geometry(7, 1, 9, 2, 1, 3, 17, 200);
    random_phase(400);
    set_geometry(5, 2, 6, 3, 0, 1, 10, 100);
    random_phase(300);
    send_idle_pct = 86; recv_idle_pct = 24;
    set_geometry(10, 3, 12, 3, 1, 255, 0, 1023);
    random_phase(350);
    set_geometry(15, 0, 15, 0, 0, 7, 40, 512);
    random_phase(150);
    send_idle_pct = 0; recv_idle_pct = 0;
    set_geometry(8, 2, 10, 1, 1, 2, 12, 90);
    random_phase(350);

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("tb_two_level_lru_cache_model: done, clean");
    else
      $display("tb_two_level_lru_cache_model: done, errors");
    $finish;
  end
endmodule
